// ----- hw/rtl/vpa_pkg.sv -----
// shared types and constants for the voice pool allocator
package vpa_pkg;

  localparam int VOICES = 32;
  localparam int VIDX_W = 5;
  localparam int MASK_W = 32;
  localparam int IN_W   = 40;
  localparam int OUT_W  = 40;

  localparam logic [VOICES-1:0] VOICE_MASK = '1;

  typedef enum logic [1:0] {
    ST_GRANT = 2'd0,
    ST_STEAL = 2'd1,
    ST_BUSY  = 2'd2,
    ST_CLEAN = 2'd3
  } status_t;

  typedef struct packed {
    logic [VIDX_W-1:0] entry;
    logic              valid;
    logic              dead;
  } cell_state_t;

  typedef struct packed {
    logic              mark;
    logic              steal;
    logic              append;
    logic [VIDX_W-1:0] value;
    logic [MASK_W-1:0] playing;
    logic [MASK_W-1:0] protect;
  } cell_ctrl_t;

endpackage

// ----- hw/rtl/vpa_cell.sv -----
// one slot of the age-ordered voice list
module vpa_cell import vpa_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cell_ctrl_t  ctrl,
  input  logic        shift_en,
  input  logic        prev_valid,
  input  cell_state_t nxt,
  output cell_state_t cur,
  output logic        drop,
  output logic        cand
);

  assign drop = cur.valid & ~ctrl.playing[cur.entry];
  assign cand = cur.valid & ~ctrl.protect[cur.entry];

  always_ff @(posedge clk) begin
    if (rst) begin
      cur.valid <= 1'b0;
      cur.dead  <= 1'b0;
    end else begin
      priority if (ctrl.mark) begin
        cur.dead <= drop;
      end else if (shift_en) begin
        if (ctrl.steal && cur.valid && !nxt.valid) begin
          cur.entry <= ctrl.value;
          cur.valid <= 1'b1;
          cur.dead  <= 1'b0;
        end else begin
          cur <= nxt;
        end
      end else if (ctrl.append && !cur.valid && prev_valid) begin
        cur.entry <= ctrl.value;
        cur.valid <= 1'b1;
        cur.dead  <= 1'b0;
      end else begin
        cur <= cur;
      end
    end
  end

endmodule

// ----- hw/rtl/voice_pool_allocator_with_stealing.sv -----
// top level: voice pool allocator with oldest-voice stealing
//
//  channel  dir  payload
//  s_*      in   action, protect_voice, playing_mask
//  m_*      out  status, voice_index, freed_mask
//
// allocate: S_ALLOC does the search and the list update in the same cycle, then S_DONE registers the result
// cleanup: S_MARK flags the freed voices, then S_SQUEEZE squeezes out one freed slot per cycle
// the list is a row of cells that shift toward the head one slot per cycle
// rst clears the list and marks every voice free; no clearing pass
// a result waiting on m_tready holds the next request only when it finishes

module voice_pool_allocator_with_stealing import vpa_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,   // action, protect_voice, playing_mask[31:0], zero pad
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata    // status[1:0], voice_index[4:0], freed_mask[31:0], zero pad
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ALLOC,
    S_MARK,
    S_SQUEEZE,
    S_DONE
  } state_t;

  state_t state;

  logic              req_protect;
  logic [MASK_W-1:0] req_playing;

  logic [VOICES-1:0] free_flags;
  logic [VOICES-1:0] protect_flags;

  status_t           res_status;
  logic [VIDX_W-1:0] res_voice;
  logic [VOICES-1:0] res_freed;

  status_t           out_status;
  logic [VIDX_W-1:0] out_voice;
  logic [MASK_W-1:0] out_freed;

  cell_ctrl_t        ctrl;
  cell_state_t       cells  [VOICES];
  cell_state_t       nxt_s  [VOICES];
  logic [VOICES-1:0] prev_v;
  logic [VOICES-1:0] valid_vec, dead_vec, drop_vec, cand_vec;
  logic [VOICES-1:0] shift_vec;

  logic [VOICES-1:0] free_low, cand_low, dead_low;
  logic [VOICES-1:0] freed_now, voice_oh;
  logic [VIDX_W-1:0] free_idx, steal_idx;
  logic              have_free, can_steal;

  // cell row
  for (genvar k = 0; k < VOICES; k++) begin : g_cell
    if (k == VOICES - 1) begin : g_end
      assign nxt_s[k] = '{entry: '0, valid: 1'b0, dead: 1'b0};
    end else begin : g_mid
      assign nxt_s[k] = cells[k+1];
    end
    if (k == 0) begin : g_head
      assign prev_v[k] = 1'b1;
    end else begin : g_body
      assign prev_v[k] = cells[k-1].valid;
    end
    assign valid_vec[k] = cells[k].valid;
    assign dead_vec[k]  = cells[k].dead;

    vpa_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .shift_en   (shift_vec[k]),
      .prev_valid (prev_v[k]),
      .nxt        (nxt_s[k]),
      .cur        (cells[k]),
      .drop       (drop_vec[k]),
      .cand       (cand_vec[k])
    );
  end

  // lowest set bits
  assign free_low = free_flags & (~free_flags + VOICES'(1));
  assign cand_low = cand_vec & (~cand_vec + VOICES'(1));
  assign dead_low = dead_vec & (~dead_vec + VOICES'(1));

  assign have_free = |free_flags;
  assign can_steal = |cand_vec;

  always_comb begin
    free_idx  = '0;
    steal_idx = '0;
    freed_now = '0;
    for (int k = 0; k < VOICES; k++) begin
      if (free_low[k]) free_idx = free_idx | VIDX_W'(k);
      if (cand_low[k]) steal_idx = steal_idx | cells[k].entry;
      if (drop_vec[k]) freed_now = freed_now | (VOICES'(1) << cells[k].entry);
    end
  end

  assign voice_oh = have_free ? free_low : (VOICES'(1) << steal_idx);

  always_comb begin
    ctrl.mark    = (state == S_MARK);
    ctrl.steal   = (state == S_ALLOC) && !have_free && can_steal;
    ctrl.append  = (state == S_ALLOC) && have_free;
    ctrl.value   = have_free ? free_idx : steal_idx;
    ctrl.playing = req_playing;
    ctrl.protect = MASK_W'(protect_flags);
    if (ctrl.steal) begin
      shift_vec = ~(cand_low - VOICES'(1));
    end else if (state == S_SQUEEZE) begin
      shift_vec = ~(dead_low - VOICES'(1));
    end else begin
      shift_vec = '0;
    end
  end

  assign s_tready = (state == S_IDLE);
  assign m_tdata  = {1'b0, out_freed, out_voice, out_status};

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      free_flags    <= VOICE_MASK;
      protect_flags <= '0;
      m_tvalid      <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != S_DONE) m_tvalid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            req_protect <= s_tdata[1];
            req_playing <= s_tdata[33:2];
            state       <= s_tdata[0] ? S_MARK : S_ALLOC;
          end
        end
        S_ALLOC: begin
          res_freed <= '0;
          if (have_free || can_steal) begin
            res_status <= have_free ? ST_GRANT : ST_STEAL;
            res_voice  <= ctrl.value;
            if (have_free) free_flags <= free_flags & ~free_low;
            protect_flags <= req_protect ? (protect_flags | voice_oh)
                                         : (protect_flags & ~voice_oh);
          end else begin
            res_status <= ST_BUSY;
            res_voice  <= '0;
          end
          state <= S_DONE;
        end
        S_MARK: begin
          res_status    <= ST_CLEAN;
          res_voice     <= '0;
          res_freed     <= freed_now;
          free_flags    <= free_flags | freed_now;
          protect_flags <= protect_flags & ~freed_now;
          state         <= S_SQUEEZE;
        end
        S_SQUEEZE: begin
          if (dead_vec == '0) state <= S_DONE;
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            out_status <= res_status;
            out_voice  <= res_voice;
            out_freed  <= MASK_W'(res_freed);
            m_tvalid   <= 1'b1;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // the list stays packed at the head; when idle it holds as many entries as voices in use
  a_list_packed: assert property (@(posedge clk) disable iff (rst)
    (valid_vec & (valid_vec + VOICES'(1))) == '0)
    else $error("voice list has a gap");

  a_list_matches_free: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> $countones(valid_vec) == $countones(~free_flags))
    else $error("list length differs from voices in use");

  a_no_dead_idle: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> dead_vec == '0)
    else $error("freed slot left in list");

  a_busy_no_voice: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (out_status == ST_BUSY || out_status == ST_CLEAN)) |-> out_voice == '0)
    else $error("voice index set without grant");

  a_cleanup_no_touch: assert property (@(posedge clk) disable iff (rst)
    (state == S_SQUEEZE) |=> $stable(free_flags))
    else $error("free flags changed while squeezing");

endmodule
